@@ hw/rtl/gme_pkg.sv @@
// Shared constants and controller/datapath interface types for the grouped mean equalizer.
package gme_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VALUE_W   = 32;
  localparam int LABEL_W   = 6;
  localparam int LABELS    = 1 << LABEL_W;
  localparam int SUM_W     = 38;
  localparam int STEP_W    = $clog2(SUM_W + 1);

  typedef struct packed {
    logic accept;
    logic lbl_rd;
    logic tab_emit;
    logic div_start;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_item;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/gme_ctrl.sv @@
// Sequencing state machine: load phase, then one division per loaded item.
module gme_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          set_end,
  input  gme_pkg::sts_t sts,
  output logic          in_ready,
  output gme_pkg::cmd_t cmd
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_DRAIN  = 3'd1;
  localparam logic [2:0] S_LBL    = 3'd2;
  localparam logic [2:0] S_TAB    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_PUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && set_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_LBL;
      end
      S_LBL: begin
        cmd.lbl_rd = 1'b1;
        state_next = S_TAB;
      end
      S_TAB: begin
        cmd.tab_emit = 1'b1;
        state_next   = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_item) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_LBL;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/gme_divider.sv @@
// Bit-serial rounded divider: magnitude plus half count, one quotient bit per cycle.
module gme_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic        [gme_pkg::SUM_W-1:0]    sum,
  input  logic        [gme_pkg::CNT_W-1:0]    cnt,
  output logic                                done,
  output logic signed [gme_pkg::VALUE_W-1:0]  mean
);

  logic [gme_pkg::STEP_W-1:0] step;
  logic [gme_pkg::SUM_W-1:0]  dvd;
  logic [gme_pkg::CNT_W-1:0]  rem;
  logic [gme_pkg::CNT_W-1:0]  den;
  logic                       neg;

  logic [gme_pkg::CNT_W-1:0]  den_start;
  logic [gme_pkg::SUM_W-1:0]  mag;
  logic [gme_pkg::CNT_W-1:0]  trial;
  logic                       qbit;
  logic [gme_pkg::VALUE_W-1:0] q_low;

  always_comb begin
    den_start = (cnt == '0) ? gme_pkg::CNT_W'(1) : cnt;
    mag       = sum[gme_pkg::SUM_W-1] ? (~sum + gme_pkg::SUM_W'(1)) : sum;
    mag       = mag + gme_pkg::SUM_W'(den_start >> 1);
    trial     = {rem[gme_pkg::CNT_W-2:0], dvd[gme_pkg::SUM_W-1]};
    qbit      = (trial >= den);
    q_low     = dvd[gme_pkg::VALUE_W-1:0];
    mean      = neg ? $signed(~q_low + gme_pkg::VALUE_W'(1)) : $signed(q_low);
    done      = (step == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= gme_pkg::STEP_W'(gme_pkg::SUM_W);
    end else if (step != '0) begin
      step <= step - gme_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sum[gme_pkg::SUM_W-1];
      dvd <= mag;
      rem <= '0;
      den <= den_start;
    end else if (step != '0) begin
      rem <= qbit ? (trial - den) : trial;
      dvd <= {dvd[gme_pkg::SUM_W-2:0], qbit};
    end
  end

endmodule

@@ hw/rtl/gme_datapath.sv @@
// Datapath: label store, per-label sum/count memories with forwarding, divider, output register.
module gme_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  gme_pkg::cmd_t                      cmd,
  output gme_pkg::sts_t                      sts,
  input  logic signed [gme_pkg::VALUE_W-1:0] charge_value,
  input  logic        [gme_pkg::LABEL_W-1:0] group_label,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gme_pkg::VALUE_W-1:0] group_mean,
  output logic        [gme_pkg::IDX_W-1:0]   item_index,
  output logic                               run_end,
  output logic                               overflowed
);

  logic [gme_pkg::LABEL_W-1:0] label_store [gme_pkg::MAX_ITEMS];
  logic [gme_pkg::SUM_W-1:0]   sum_mem     [gme_pkg::LABELS];
  logic [gme_pkg::CNT_W-1:0]   cnt_mem     [gme_pkg::LABELS];
  logic [gme_pkg::LABELS-1:0]  vld;

  logic [gme_pkg::CNT_W-1:0]   items_loaded;
  logic                        overflow_seen;
  logic [gme_pkg::IDX_W-1:0]   idx;
  logic                        full;

  logic [gme_pkg::LABEL_W-1:0] rd_lbl;
  logic [gme_pkg::SUM_W-1:0]   rd_sum;
  logic [gme_pkg::CNT_W-1:0]   rd_cnt;
  logic                        rd_vld;
  logic [gme_pkg::LABEL_W-1:0] taddr;

  logic                        s_valid;
  logic [gme_pkg::LABEL_W-1:0] s_label;
  logic [gme_pkg::VALUE_W-1:0] s_value;
  logic                        s_fwd;
  logic [gme_pkg::SUM_W-1:0]   fwd_sum;
  logic [gme_pkg::CNT_W-1:0]   fwd_cnt;
  logic [gme_pkg::SUM_W-1:0]   base_sum;
  logic [gme_pkg::CNT_W-1:0]   base_cnt;
  logic [gme_pkg::SUM_W-1:0]   new_sum;
  logic [gme_pkg::CNT_W-1:0]   new_cnt;

  logic                               div_done;
  logic signed [gme_pkg::VALUE_W-1:0] div_mean;

  always_comb begin
    full     = (items_loaded == gme_pkg::CNT_W'(gme_pkg::MAX_ITEMS));
    taddr    = cmd.tab_emit ? rd_lbl : group_label;
    base_sum = s_fwd ? fwd_sum : (rd_vld ? rd_sum : '0);
    base_cnt = s_fwd ? fwd_cnt : (rd_vld ? rd_cnt : '0);
    new_sum  = base_sum + {{(gme_pkg::SUM_W-gme_pkg::VALUE_W){s_value[gme_pkg::VALUE_W-1]}},
                           s_value};
    new_cnt  = base_cnt + gme_pkg::CNT_W'(1);
    sts.last_item = (({1'b0, idx} + gme_pkg::CNT_W'(1)) == items_loaded);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      items_loaded  <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      vld           <= '0;
      s_valid       <= 1'b0;
    end else begin
      s_valid <= cmd.accept && !full;
      if (cmd.accept) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          items_loaded <= items_loaded + gme_pkg::CNT_W'(1);
        end
      end
      if (s_valid) begin
        vld[s_label] <= 1'b1;
      end
      if (cmd.out_load) begin
        idx <= idx + gme_pkg::IDX_W'(1);
      end
    end
  end

  // load stage and forwarding
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_label <= group_label;
      s_value <= charge_value;
      s_fwd   <= s_valid && (s_label == group_label);
      fwd_sum <= new_sum;
      fwd_cnt <= new_cnt;
    end
  end

  // label store
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      label_store[items_loaded[gme_pkg::IDX_W-1:0]] <= group_label;
    end
    if (cmd.lbl_rd) begin
      rd_lbl <= label_store[idx];
    end
  end

  // sum and count tables
  always_ff @(posedge clk) begin
    if (s_valid) begin
      sum_mem[s_label] <= new_sum;
      cnt_mem[s_label] <= new_cnt;
    end
    rd_sum <= sum_mem[taddr];
    rd_cnt <= cnt_mem[taddr];
    rd_vld <= vld[taddr];
  end

  gme_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .sum   (rd_vld ? rd_sum : '0),
    .cnt   (rd_vld ? rd_cnt : '0),
    .done  (div_done),
    .mean  (div_mean)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      group_mean <= div_mean;
      item_index <= idx;
      run_end    <= sts.last_item;
      overflowed <= overflow_seen;
    end
  end

endmodule

@@ hw/rtl/grouped_mean_equalizer.sv @@
// Top level of the grouped mean equalizer: controller, datapath and checks.
// Loads one word per cycle while in_ready is high; a word with set_end ends the set. Up to 64
// words are kept per set, later ones are dropped and flag overflowed on every result. After the
// last word, one result per kept word comes out in load order, each after label read, table
// read, divider start, the quotient-bit steps and the done check, then output load, plus any
// output stall. in_ready stays low from set_end until the last result is placed in the output
// register; the tables are cleared in the same cycle.
module grouped_mean_equalizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gme_pkg::VALUE_W-1:0] charge_value,
  input  logic        [gme_pkg::LABEL_W-1:0] group_label,
  input  logic                               set_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gme_pkg::VALUE_W-1:0] group_mean,
  output logic        [gme_pkg::IDX_W-1:0]   item_index,
  output logic                               run_end,
  output logic                               overflowed
);

  gme_pkg::cmd_t cmd;
  gme_pkg::sts_t sts;

  gme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .set_end  (set_end),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gme_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .charge_value (charge_value),
    .group_label  (group_label),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .group_mean   (group_mean),
    .item_index   (item_index),
    .run_end      (run_end),
    .overflowed   (overflowed)
  );

  a_stop_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && set_end) |=> !in_ready)
    else $error("input still open after set_end word");

  a_no_load_midset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_end) |-> !in_ready)
    else $error("input open while results of a set are pending");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (cmd.clear == sts.last_item))
    else $error("tables not cleared with last result");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for grouped_mean_equalizer: random sets with group-mean prediction.
module tb_top;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [gme_pkg::VALUE_W-1:0] value;
    logic        [gme_pkg::LABEL_W-1:0] label;
    logic                               last;
    bit                                 drain_first;
  } charge_word_t;

  typedef struct {
    logic signed [gme_pkg::VALUE_W-1:0] mean;
    logic        [gme_pkg::IDX_W-1:0]   index;
    logic                               run_end;
    logic                               overflowed;
  } group_result_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [gme_pkg::VALUE_W-1:0] charge_value = '0;
  logic        [gme_pkg::LABEL_W-1:0] group_label = '0;
  logic                               set_end = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [gme_pkg::VALUE_W-1:0] group_mean;
  logic        [gme_pkg::IDX_W-1:0]   item_index;
  logic                               run_end;
  logic                               overflowed;

  charge_word_t  pending_charges[$];
  group_result_t expected_means[$];
  charge_word_t  next_word;
  group_result_t want;

  logic [gme_pkg::LABEL_W-1:0] set_labels [gme_pkg::MAX_ITEMS];
  longint                      group_sum [gme_pkg::LABELS];
  int                          group_count [gme_pkg::LABELS];
  int                          set_fill = 0;
  bit                          set_dropped = 1'b0;

  int words_planned = 0;
  int words_accepted = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int results_checked = 0;
  int errors = 0;
  int in_gap = 0;
  int in_burst = 0;
  int out_gap = 0;
  int out_burst = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  grouped_mean_equalizer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .charge_value (charge_value),
    .group_label  (group_label),
    .set_end      (set_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .group_mean   (group_mean),
    .item_index   (item_index),
    .run_end      (run_end),
    .overflowed   (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [gme_pkg::VALUE_W-1:0] rounded_group_mean(
      input longint total, input int n);
    longint mag;
    longint q;
    mag = (total < 0) ? -total : total;
    q = (mag + n / 2) / n;
    return gme_pkg::VALUE_W'((total < 0) ? -q : q);
  endfunction

  task automatic absorb_charge(input logic signed [gme_pkg::VALUE_W-1:0] value,
                               input logic [gme_pkg::LABEL_W-1:0] label, input logic last);
    group_result_t res;
    int i;
    if (set_fill < gme_pkg::MAX_ITEMS) begin
      set_labels[set_fill] = label;
      group_sum[label] += value;
      group_count[label]++;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (i = 0; i < set_fill; i++) begin
        res.mean       = rounded_group_mean(group_sum[set_labels[i]],
                                            group_count[set_labels[i]]);
        res.index      = gme_pkg::IDX_W'(i);
        res.run_end    = (i == set_fill - 1);
        res.overflowed = set_dropped;
        expected_means = {expected_means, res};
      end
      if (set_dropped) overflow_sets++;
      sets_closed++;
      for (i = 0; i < gme_pkg::LABELS; i++) begin
        group_sum[i]   = 0;
        group_count[i] = 0;
      end
      set_fill    = 0;
      set_dropped = 1'b0;
    end
    words_accepted++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    errors++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [gme_pkg::VALUE_W-1:0] pick_charge();
    int r;
    int near;
    r = $urandom_range(0, 9);
    near = $urandom_range(0, 16);
    if (r < 4) return $urandom;
    if (r < 7) return near - 8;
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic add_charge(input logic signed [gme_pkg::VALUE_W-1:0] value,
                            input logic [gme_pkg::LABEL_W-1:0] label, input logic last,
                            input bit drain_first);
    charge_word_t w;
    w.value       = value;
    w.label       = label;
    w.last        = last;
    w.drain_first = drain_first;
    pending_charges = {pending_charges, w};
    words_planned++;
  endtask

  task automatic add_set(input int n, input bit drain_first);
    logic [gme_pkg::LABEL_W-1:0] pool [4];
    logic [gme_pkg::LABEL_W-1:0] lbl;
    int mode;
    int pool_n;
    int i;
    mode   = $urandom_range(0, 19);
    pool_n = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) pool[i] = gme_pkg::LABEL_W'($urandom);
    for (i = 0; i < n; i++) begin
      if (mode < 12) lbl = pool[$urandom_range(0, pool_n - 1)];
      else if (mode < 17) lbl = gme_pkg::LABEL_W'($urandom);
      else lbl = pool[0];
      add_charge(pick_charge(), lbl, i == n - 1, drain_first && i == 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_charge(charge_value, group_label, set_end);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_charges.size() != 0 &&
                     !(pending_charges[0].drain_first && expected_means.size() != 0)) begin
          next_word = pending_charges.pop_front();
          in_valid     <= 1'b1;
          charge_value <= next_word.value;
          group_label  <= next_word.label;
          set_end      <= next_word.last;
          if (in_burst != 0) begin
            in_burst--;
            in_gap = 0;
          end else begin
            in_gap = draw_gap();
            if ($urandom_range(0, 19) == 0) in_burst = $urandom_range(10, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("unexpected result, index %0d mean %0d",
                                    item_index, group_mean));
        end else begin
          want = expected_means.pop_front();
          if (group_mean !== want.mean)
            report_mismatch($sformatf("group_mean expected %0d got %0d",
                                      want.mean, group_mean));
          if (item_index !== want.index)
            report_mismatch($sformatf("item_index expected %0d got %0d",
                                      want.index, item_index));
          if (run_end !== want.run_end)
            report_mismatch($sformatf("run_end expected %0b got %0b", want.run_end, run_end));
          if (overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed expected %0b got %0b",
                                      want.overflowed, overflowed));
        end
        results_checked++;
        if (out_burst != 0) begin
          out_burst--;
          out_gap = 0;
        end else begin
          out_gap = draw_gap();
          if ($urandom_range(0, 19) == 0) out_burst = $urandom_range(10, 40);
        end
        if (results_checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no word moved for %0d cycles, %0d results still due",
               QUIET_LIMIT, expected_means.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int small_words;
    int n;
    bit over_done;
    small_words = 0;
    over_done   = 1'b0;

    add_charge(32'sh7FFF_FFFF, 6'd63, 1'b1, 1'b0);
    add_charge(32'sh8000_0000, 6'd0, 1'b1, 1'b0);
    add_charge(1, 6'd5, 1'b0, 1'b0);
    add_charge(2, 6'd5, 1'b0, 1'b0);
    add_charge(-1, 6'd6, 1'b0, 1'b0);
    add_charge(-2, 6'd6, 1'b0, 1'b0);
    add_charge(7, 6'd9, 1'b1, 1'b0);
    add_charge(32'sh7FFF_FFFF, 6'd10, 1'b0, 1'b0);
    add_charge(32'sh7FFF_FFFF, 6'd10, 1'b0, 1'b0);
    add_charge(32'sh8000_0000, 6'd11, 1'b0, 1'b0);
    add_charge(32'sh8000_0000, 6'd11, 1'b0, 1'b0);
    add_charge(32'sh7FFF_FFFF, 6'd12, 1'b0, 1'b0);
    add_charge(32'sh8000_0000, 6'd12, 1'b1, 1'b0);
    add_charge(2, 6'd3, 1'b0, 1'b0);
    add_charge(0, 6'd3, 1'b0, 1'b0);
    add_charge(0, 6'd3, 1'b0, 1'b0);
    add_charge(-2, 6'd40, 1'b0, 1'b0);
    add_charge(0, 6'd40, 1'b0, 1'b0);
    add_charge(0, 6'd40, 1'b1, 1'b0);

    while (small_words < 25) begin
      if (!over_done && small_words >= 10) begin
        add_set(gme_pkg::MAX_ITEMS + $urandom_range(1, 3), 1'b1);
        over_done = 1'b1;
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      add_set(n, 1'b0);
      small_words += n;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (words_accepted != words_planned) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d words in %0d sets, %0d of them past capacity", words_accepted,
             sets_closed, overflow_sets);
    $display("checked %0d group means with random gaps and a long output stall",
             results_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
